// File: hw/rtl/tsc_pkg.sv
// Package for the tickless system clock: widths, constants, operation and
// register codes, and the command/status structs between controller and datapath.
// No dependencies.
package tsc_pkg;

  localparam int unsigned COUNTER_BITS_DEF = 16;

  localparam int unsigned OP_W         = 2;
  localparam int unsigned CNT_W        = 16;
  localparam int unsigned WAKE_W       = 16;
  localparam int unsigned SEC_W        = 32;
  localparam int unsigned MILLI_W      = 10;
  localparam int unsigned MILLIS_OUT_W = 17;
  localparam int unsigned MPP_W        = 10;
  localparam int unsigned TPM_W        = 16;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned PROD_W       = MPP_W + TPM_W;
  localparam int unsigned DIV_STEPS    = CNT_W;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam int unsigned MS_PER_SEC   = 1000;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_SCHED = 2'd2,
    OP_MATCH = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MS_PER_PERIOD = 1'b0,
    REG_TICKS_PER_MS  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic mul;
    logic div_step;
    logic load_out;
  } tsc_cmd_t;

  typedef struct packed {
    op_t op;
  } tsc_sts_t;

endpackage

// File: hw/rtl/tsc_in_if.sv
// Input request channel of the tickless system clock.
// Depends on tsc_pkg for field widths.
interface tsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [tsc_pkg::OP_W-1:0]      op;
  logic [tsc_pkg::CNT_W-1:0]     count_now;
  logic [tsc_pkg::WAKE_W-1:0]    wake_ms;

  modport source (output valid, op, count_now, wake_ms, input ready);
  modport sink   (input valid, op, count_now, wake_ms, output ready);
endinterface

// File: hw/rtl/tsc_out_if.sv
// Result channel of the tickless system clock.
// Depends on tsc_pkg for field widths.
interface tsc_out_if;
  logic                               valid;
  logic                               ready;
  logic [tsc_pkg::SEC_W-1:0]          time_seconds;
  logic [tsc_pkg::MILLIS_OUT_W-1:0]   time_millis;
  logic                               poll_request;
  logic                               counter_clear;
  logic                               compare_write;
  logic [tsc_pkg::CNT_W-1:0]          compare_value;

  modport source (output valid, time_seconds, time_millis, poll_request, counter_clear,
                  compare_write, compare_value, input ready);
  modport sink   (input valid, time_seconds, time_millis, poll_request, counter_clear,
                  compare_write, compare_value, output ready);
endinterface

// File: hw/rtl/tsc_cfg_if.sv
// Configuration write channel of the tickless system clock.
// Depends on tsc_pkg for index and data widths.
interface tsc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tsc_pkg::CFG_IDX_W-1:0]     index;
  logic [tsc_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/tsc_ctrl.sv
// Controller state machine of the tickless system clock.
// Sequences capture, execute, multiply, divide and result load; uses tsc_pkg.
module tsc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tsc_pkg::tsc_sts_t sts,
  output tsc_pkg::tsc_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  localparam int unsigned CW = tsc_pkg::DIV_CNT_W;
  localparam logic [CW-1:0] DIV_LAST = CW'(tsc_pkg::DIV_STEPS - 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.op)
          tsc_pkg::OP_READ:  state_nxt = S_DIV;
          tsc_pkg::OP_SCHED: state_nxt = S_MUL;
          default:           state_nxt = S_DONE;
        endcase
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == DIV_LAST) begin
          step_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r + CW'(1);
        end
      end
      S_DONE: begin
        // The finished result waits here until the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/tsc_dp.sv
// Datapath of the tickless system clock: time state, configuration registers,
// bit-serial divider, schedule multiplier and result register. Uses tsc_pkg.
module tsc_dp #(
  parameter int unsigned COUNTER_BITS = tsc_pkg::COUNTER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [tsc_pkg::OP_W-1:0]            in_op,
  input  logic [tsc_pkg::CNT_W-1:0]           in_count_now,
  input  logic [tsc_pkg::WAKE_W-1:0]          in_wake_ms,
  input  logic                                cfg_wr,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tsc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  tsc_pkg::tsc_cmd_t                   cmd,
  output tsc_pkg::tsc_sts_t                   sts,
  output logic [tsc_pkg::SEC_W-1:0]           out_time_seconds,
  output logic [tsc_pkg::MILLIS_OUT_W-1:0]    out_time_millis,
  output logic                                out_poll_request,
  output logic                                out_counter_clear,
  output logic                                out_compare_write,
  output logic [tsc_pkg::CNT_W-1:0]           out_compare_value
);

  localparam int unsigned CW  = tsc_pkg::CNT_W;
  localparam int unsigned WW  = tsc_pkg::WAKE_W;
  localparam int unsigned SW  = tsc_pkg::SEC_W;
  localparam int unsigned MW  = tsc_pkg::MILLI_W;
  localparam int unsigned OW  = tsc_pkg::MILLIS_OUT_W;
  localparam int unsigned PW  = tsc_pkg::MPP_W;
  localparam int unsigned TW  = tsc_pkg::TPM_W;
  localparam int unsigned XW  = tsc_pkg::PROD_W;
  localparam int unsigned SUMW = MW + 1;
  localparam logic [CW-1:0]   CNT_MASK = CW'((32'd1 << COUNTER_BITS) - 32'd1);
  localparam logic [SUMW-1:0] ONE_SEC  = SUMW'(tsc_pkg::MS_PER_SEC);
  localparam logic [SUMW-1:0] TWO_SEC  = SUMW'(2 * tsc_pkg::MS_PER_SEC);

  logic [PW-1:0]  mpp_r;
  logic [TW-1:0]  tpm_r;
  logic [SW-1:0]  sec_r;
  logic [MW-1:0]  milli_r;

  tsc_pkg::op_t   op_r;
  logic [CW-1:0]  cnt_r;
  logic [WW-1:0]  wake_r;

  logic [TW-1:0]  rem_r;
  logic [CW-1:0]  quo_r;

  logic           ahead_r;
  logic           inper_r;
  logic [PW-1:0]  diff_r;
  logic [CW-1:0]  prod_r;

  logic [SW-1:0]  o_sec_r;
  logic [OW-1:0]  o_millis_r;
  logic           o_poll_r, o_clr_r, o_cw_r;
  logic [CW-1:0]  o_cv_r;

  logic [TW-1:0]  tpm_eff;
  logic [PW-1:0]  per_eff;
  logic [SUMW-1:0] m_sum;
  logic [SUMW-1:0] m_wrap;
  logic [1:0]      carry;
  logic [WW-1:0]  diff_full;
  logic [TW:0]    div_trial;
  logic [TW:0]    div_sub;
  logic [XW-1:0]  prod_full;
  logic [OW-1:0]  millis_res;
  logic           poll_res, clr_res, cw_res;
  logic [CW-1:0]  cv_res;

  assign sts.op  = op_r;
  assign tpm_eff = (tpm_r == '0) ? TW'(1) : tpm_r;
  assign per_eff = (mpp_r == '0) ? PW'(1) : mpp_r;

  // Period tick: the sum stays below two thousand and some, so at most two
  // whole seconds carry out.
  always_comb begin
    m_sum = SUMW'(milli_r) + SUMW'(mpp_r);
    if (m_sum >= TWO_SEC) begin
      m_wrap = m_sum - TWO_SEC;
      carry  = 2'd2;
    end else if (m_sum >= ONE_SEC) begin
      m_wrap = m_sum - ONE_SEC;
      carry  = 2'd1;
    end else begin
      m_wrap = m_sum;
      carry  = 2'd0;
    end
  end

  assign diff_full = wake_r - WW'(milli_r);

  // One restoring division step: shift the next dividend bit into the remainder.
  assign div_trial = {rem_r, quo_r[CW-1]};
  assign div_sub   = div_trial - (TW+1)'(tpm_eff);

  assign prod_full = XW'(diff_r) * XW'(tpm_eff);

  always_comb begin
    millis_res = OW'(milli_r);
    poll_res   = 1'b0;
    clr_res    = 1'b0;
    cw_res     = 1'b0;
    cv_res     = '0;
    case (op_r)
      tsc_pkg::OP_TICK: begin
        poll_res = 1'b1;
        clr_res  = 1'b1;
      end
      tsc_pkg::OP_READ: begin
        millis_res = OW'(milli_r) + OW'(quo_r);
      end
      tsc_pkg::OP_SCHED: begin
        if (!ahead_r) begin
          poll_res = 1'b1;
        end else if (inper_r) begin
          cw_res = 1'b1;
          // The target has already passed within this period.
          if (cnt_r >= prod_r) begin
            cv_res   = CNT_MASK;
            poll_res = 1'b1;
          end else begin
            cv_res = prod_r & CNT_MASK;
          end
        end
      end
      tsc_pkg::OP_MATCH: begin
        cw_res   = 1'b1;
        cv_res   = CNT_MASK;
        poll_res = 1'b1;
      end
      default: begin
        poll_res = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpp_r   <= PW'(1);
      tpm_r   <= TW'(1);
      sec_r   <= '0;
      milli_r <= '0;
      op_r    <= tsc_pkg::OP_TICK;
    end else begin
      if (cfg_wr) begin
        case (tsc_pkg::cfg_reg_t'(cfg_index))
          tsc_pkg::REG_MS_PER_PERIOD: mpp_r <= cfg_data[PW-1:0];
          tsc_pkg::REG_TICKS_PER_MS:  tpm_r <= cfg_data[TW-1:0];
          default: ;
        endcase
      end
      if (cmd.capture) begin
        op_r <= tsc_pkg::op_t'(in_op);
      end
      if (cmd.exec && (op_r == tsc_pkg::OP_TICK)) begin
        sec_r   <= sec_r + SW'(carry);
        milli_r <= m_wrap[MW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cnt_r  <= in_count_now & CNT_MASK;
      wake_r <= in_wake_ms;
      quo_r  <= in_count_now & CNT_MASK;
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      if (!div_sub[TW]) begin
        rem_r <= div_sub[TW-1:0];
        quo_r <= {quo_r[CW-2:0], 1'b1};
      end else begin
        rem_r <= div_trial[TW-1:0];
        quo_r <= {quo_r[CW-2:0], 1'b0};
      end
    end
    if (cmd.exec) begin
      ahead_r <= (WW'(milli_r) < wake_r);
      inper_r <= (diff_full < WW'(per_eff));
      diff_r  <= diff_full[PW-1:0];
    end
    if (cmd.mul) begin
      prod_r <= prod_full[CW-1:0];
    end
    if (cmd.load_out) begin
      o_sec_r    <= sec_r;
      o_millis_r <= millis_res;
      o_poll_r   <= poll_res;
      o_clr_r    <= clr_res;
      o_cw_r     <= cw_res;
      o_cv_r     <= cv_res;
    end
  end

  assign out_time_seconds  = o_sec_r;
  assign out_time_millis   = o_millis_r;
  assign out_poll_request  = o_poll_r;
  assign out_counter_clear = o_clr_r;
  assign out_compare_write = o_cw_r;
  assign out_compare_value = o_cv_r;

endmodule

// File: hw/rtl/tickless_system_clock.sv
// Tickless system clock: one request in, one result out, one request at a time.
// A period tick or compare match passes through the execute and done states, a
// schedule request through execute, multiply and done, and a read through
// execute, the 16 steps of the bit-serial divider that turns the sampled counter
// into milliseconds, and done. The finished result sits in an output register, so
// a new request is taken while it waits to be collected. Configuration writes are
// accepted in every cycle and are meant to be made while the block is idle.
// Depends on tsc_pkg, the three channel interfaces, tsc_ctrl and tsc_dp.
module tickless_system_clock #(
  parameter int unsigned COUNTER_BITS = tsc_pkg::COUNTER_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  tsc_in_if.sink    in_if,
  tsc_out_if.source out_if,
  tsc_cfg_if.sink   cfg_if
);

  tsc_pkg::tsc_cmd_t cmd;
  tsc_pkg::tsc_sts_t sts;
  logic              in_ready;
  logic              cfg_wr;

  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_wr       = cfg_if.valid;

  tsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tsc_dp #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_op             (in_if.op),
    .in_count_now      (in_if.count_now),
    .in_wake_ms        (in_if.wake_ms),
    .cfg_wr            (cfg_wr),
    .cfg_index         (cfg_if.index),
    .cfg_data          (cfg_if.data),
    .cmd               (cmd),
    .sts               (sts),
    .out_time_seconds  (out_if.time_seconds),
    .out_time_millis   (out_if.time_millis),
    .out_poll_request  (out_if.poll_request),
    .out_counter_clear (out_if.counter_clear),
    .out_compare_write (out_if.compare_write),
    .out_compare_value (out_if.compare_value)
  );

endmodule
